### hw/rtl/assert_macros.svh
// assert_macros.svh - assertion shorthands for the chord matcher checker.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/kcbm_pkg.sv
// kcbm_pkg.sv - types and fixed field widths of the key chord binding matcher.
// No dependencies; used by the top level and the checker.
package kcbm_pkg;

    // Fixed payload field widths
    localparam int SLOT_FIELD_W = 5;
    localparam int STEP_FIELD_W = 2;
    localparam int KEY_FIELD_W  = 8;
    localparam int MOD_W        = 4;
    localparam int TOTAL_W      = 3;
    localparam int CMD_W        = 8;
    localparam int LEVEL_W      = 2;

    typedef enum logic [1:0] {
        OP_KEY  = 2'd0,
        OP_STEP = 2'd1,
        OP_HDR  = 2'd2,
        OP_RST  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op                      operation;
        logic [SLOT_FIELD_W-1:0]  binding_slot;
        logic [STEP_FIELD_W-1:0]  step_slot;
        logic [KEY_FIELD_W-1:0]   key_code;
        logic [MOD_W-1:0]         modifier_bits;
        logic [TOTAL_W-1:0]       step_total;
        logic [CMD_W-1:0]         command_in;
    } t_in;

    typedef struct packed {
        logic                     fired;
        logic [CMD_W-1:0]         command_out;
        logic [SLOT_FIELD_W-1:0]  fired_slot;
        logic                     chord_pending;
        logic [LEVEL_W-1:0]       chord_level;
    } t_out;

endpackage

### hw/rtl/kcbm_ram.sv
// kcbm_ram.sv - generic single-write, single-read RAM with registered read.
// No dependencies; used by the chord matcher top level.
module kcbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/key_chord_binding_matcher_top.sv
// key_chord_binding_matcher_top.sv - multi-key chord shortcut matcher.
// Depends on kcbm_pkg (types) and kcbm_ram (step table, header table).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) carries keystrokes,
//   binding step writes, binding header writes and reset-chord requests.
//   Output channel (o_out_valid / i_out_ready, payload o_out) returns exactly
//   one result per input transfer, in order.
//   A keystroke walks the binding table one binding per cycle through a
//   shared compare unit fed by the registered-read tables; after the scan
//   state, the settle state loads the result into the output register and
//   returns to idle, where the next item is taken.
//   Table writes and reset-chord go from idle straight to the settle state.
//   The block takes one item at a time; o_in_ready is high only when idle.
//   The result sits in an output register, so the next item is accepted while
//   a result waits; if the receiver stalls, a second result holds in the
//   settle state until the output register frees up.
//   Reset (synchronous, active low) disables all bindings and clears the chord.
//   Step keys and commands read as undefined until written.
module key_chord_binding_matcher_top
    import kcbm_pkg::*;
#(
    parameter int NUM_BINDINGS = 32,
    parameter int MAX_STEPS    = 4,
    parameter int KEY_BITS     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int SLOT_W   = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
    localparam int CNT_W    = $clog2(NUM_BINDINGS + 1);
    localparam int DEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LEN_W    = $clog2(MAX_STEPS + 1);
    localparam int STEP_DEPTH = NUM_BINDINGS * MAX_STEPS;
    localparam int STEP_AW  = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
    localparam int PROBE_W  = KEY_BITS + MOD_W;
    localparam int HDR_W    = LEN_W + CMD_W;

    // Control state
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_rd_vld;
    logic [SLOT_W-1:0]       r_rd_idx;
    logic                    r_is_key;
    logic [NUM_BINDINGS-1:0] r_hdr_valid;
    logic [NUM_BINDINGS-1:0] r_mask;
    logic [NUM_BINDINGS-1:0] r_next;
    logic                    r_pending;
    logic [DEP_W-1:0]        r_depth;
    logic                    r_any;
    logic                    r_hit_f;
    logic [SLOT_W-1:0]       r_hit_slot;
    logic [CMD_W-1:0]        r_hit_cmd;
    logic [PROBE_W-1:0]      r_probe;
    logic                    r_out_valid;
    t_out                    r_out;
    t_out                    n_out;

    // Handshake and sequencer strobes
    logic w_in_acc;
    logic w_out_free;
    logic w_issue;
    logic w_fin_go;

    // Table ports
    logic                w_step_we;
    logic [STEP_AW-1:0]  w_step_waddr;
    logic [STEP_AW-1:0]  w_step_raddr;
    logic [PROBE_W-1:0]  w_step_wdata;
    logic [PROBE_W-1:0]  w_step_rd;
    logic                w_hdr_we;
    logic [SLOT_W-1:0]   w_wslot;
    logic [LEN_W-1:0]    w_len_sat;
    logic [HDR_W-1:0]    w_hdr_rd;

    // Compare unit
    logic [LEN_W-1:0]    w_len;
    logic [LEN_W-1:0]    w_depth_ext;
    logic                w_cand;
    logic                w_match;
    logic                w_last;
    logic [KEY_BITS-1:0] w_key;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.operation == OP_KEY) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (r_idx == CNT_W'(NUM_BINDINGS)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_fin_go   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: w_issue    = (r_idx != CNT_W'(NUM_BINDINGS));
            ST_FIN:  w_fin_go   = w_out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Table write side, straight from the accepted item
    assign w_key        = KEY_BITS'(i_in.key_code);
    assign w_step_wdata = {i_in.modifier_bits, w_key};
    assign w_wslot      = SLOT_W'(i_in.binding_slot);
    assign w_step_waddr = STEP_AW'(int'(i_in.binding_slot) * MAX_STEPS
                                   + int'(i_in.step_slot));
    assign w_step_we    = w_in_acc && (i_in.operation == OP_STEP)
                          && (int'(i_in.binding_slot) < NUM_BINDINGS)
                          && (int'(i_in.step_slot) < MAX_STEPS);
    assign w_hdr_we     = w_in_acc && (i_in.operation == OP_HDR)
                          && (int'(i_in.binding_slot) < NUM_BINDINGS);
    // step count saturates at the table's step capacity
    assign w_len_sat    = (int'(i_in.step_total) > MAX_STEPS) ? LEN_W'(MAX_STEPS)
                                                              : LEN_W'(i_in.step_total);

    // Table read side: binding r_idx, step r_depth
    assign w_step_raddr = STEP_AW'(int'(r_idx[SLOT_W-1:0]) * MAX_STEPS + int'(r_depth));

    kcbm_ram #(
        .WIDTH (PROBE_W),
        .DEPTH (STEP_DEPTH)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (w_step_we),
        .i_waddr (w_step_waddr),
        .i_wdata (w_step_wdata),
        .i_raddr (w_step_raddr),
        .o_rdata (w_step_rd)
    );

    kcbm_ram #(
        .WIDTH (HDR_W),
        .DEPTH (NUM_BINDINGS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_hdr_we),
        .i_waddr (w_wslot),
        .i_wdata ({w_len_sat, i_in.command_in}),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (w_hdr_rd)
    );

    // Compare unit: one binding per cycle; unwritten headers read as disabled
    assign w_depth_ext = LEN_W'(r_depth);
    assign w_len       = r_hdr_valid[r_rd_idx] ? w_hdr_rd[HDR_W-1:CMD_W] : '0;
    assign w_cand      = !r_pending || r_mask[r_rd_idx];
    assign w_match     = r_rd_vld && w_cand && (w_depth_ext < w_len)
                         && (w_step_rd == r_probe);
    assign w_last      = (w_len == w_depth_ext + LEN_W'(1));

    // Sequencer and chord state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_is_key    <= 1'b0;
            r_hdr_valid <= '0;
            r_mask      <= '0;
            r_next      <= '0;
            r_pending   <= 1'b0;
            r_depth     <= '0;
            r_any       <= 1'b0;
            r_hit_f     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;

            // item transfer: arm the scan
            if (w_in_acc) begin
                r_idx    <= '0;
                r_is_key <= (i_in.operation == OP_KEY);
                r_next   <= '0;
                r_any    <= 1'b0;
                r_hit_f  <= 1'b0;
            end else if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end

            if (w_hdr_we) begin
                r_hdr_valid[w_wslot] <= 1'b1;
            end

            // record matches; the first completing binding wins
            if (w_match) begin
                r_next[r_rd_idx] <= 1'b1;
                r_any            <= 1'b1;
                if (!r_hit_f && w_last) begin
                    r_hit_f <= 1'b1;
                end
            end

            // settle: update the chord
            if (w_fin_go) begin
                if (r_is_key && !r_hit_f && r_any) begin
                    r_mask    <= r_next;
                    r_pending <= 1'b1;
                    r_depth   <= r_depth + DEP_W'(1);
                end else begin
                    r_mask    <= '0;
                    r_pending <= 1'b0;
                    r_depth   <= '0;
                end
            end

            // output register
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result of the finished item
    always_comb begin
        n_out = '0;
        if (r_is_key && r_hit_f) begin
            n_out.fired       = 1'b1;
            n_out.command_out = r_hit_cmd;
            n_out.fired_slot  = SLOT_FIELD_W'(r_hit_slot);
        end else if (r_is_key && r_any) begin
            n_out.chord_pending = 1'b1;
            n_out.chord_level   = LEVEL_W'(r_depth + DEP_W'(1));
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // binding whose table data arrives next cycle
        r_rd_idx <= r_idx[SLOT_W-1:0];
        if (w_in_acc) begin
            r_probe <= {i_in.modifier_bits, w_key};
        end
        if (w_match && !r_hit_f && w_last) begin
            r_hit_slot <= r_rd_idx;
            r_hit_cmd  <= w_hdr_rd[CMD_W-1:0];
        end
        if (w_fin_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hw/rtl/kcbm_checker.sv
// kcbm_checker.sv - port-level checks for the chord matcher, bound to the top.
// Depends on kcbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcbm_checker
    import kcbm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a result waits in the output register until its transfer
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // one item at a time: after an input transfer the block is busy
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a fired binding always ends the chord
    `ASSERT_IMPLY(a_fire_clears, i_clk, i_rst_n, o_out_valid && o_out.fired,
                  !o_out.chord_pending && (o_out.chord_level == '0))

    // without a fire, command and slot are zero
    `ASSERT_IMPLY(a_nofire_zero, i_clk, i_rst_n, o_out_valid && !o_out.fired,
                  (o_out.command_out == '0) && (o_out.fired_slot == '0))

    // a nonzero chord level only while a chord is pending
    `ASSERT_IMPLY(a_level_pending, i_clk, i_rst_n,
                  o_out_valid && (o_out.chord_level != '0), o_out.chord_pending)

endmodule

bind key_chord_binding_matcher_top kcbm_checker u_kcbm_checker (.*);
